/* hdl/assert_macros.svh */
// Assertion helpers, clocked on a named clock and disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/cbp_pkg.sv */
package cbp_pkg;

    localparam int WORD_W          = 32;
    localparam int FIELD_W         = 64;
    localparam int N_WORDS         = 16;
    localparam int DOUBLE_ROUNDS_D = 10;
    localparam int STEPS_PER_DR    = 8;

    typedef logic [WORD_W-1:0]              t_word;
    typedef logic [N_WORDS-1:0][WORD_W-1:0] t_state;
    typedef logic [1:0]                     t_step;

    localparam t_step STEP_AD16 = 2'd0;
    localparam t_step STEP_CB12 = 2'd1;
    localparam t_step STEP_AD8  = 2'd2;
    localparam t_step STEP_CB7  = 2'd3;

    localparam logic [4:0] ROT_16 = 5'd16;
    localparam logic [4:0] ROT_12 = 5'd12;
    localparam logic [4:0] ROT_8  = 5'd8;
    localparam logic [4:0] ROT_7  = 5'd7;

    function automatic t_word rotl(t_word v, logic [4:0] s);
        logic [2*WORD_W-1:0] x;
        begin
            x = {v, v} << s;
            return x[2*WORD_W-1:WORD_W];
        end
    endfunction

    // row = position in the quarter-round, column shifts by row on diagonals
    function automatic logic [3:0] word_idx(logic diag, logic [1:0] q, logic [1:0] pos);
        logic [1:0] col;
        begin
            col = q + (diag ? pos : 2'd0);
            return {pos, col};
        end
    endfunction

    function automatic t_state qr_step(t_state s, logic diag, t_step step, logic [1:0] q);
        t_state     r;
        logic [3:0] ia;
        logic [3:0] ib;
        logic [3:0] ic;
        logic [3:0] id;
        t_word      a;
        t_word      b;
        t_word      c;
        t_word      d;
        begin
            ia = word_idx(diag, q, 2'd0);
            ib = word_idx(diag, q, 2'd1);
            ic = word_idx(diag, q, 2'd2);
            id = word_idx(diag, q, 2'd3);
            a  = s[ia];
            b  = s[ib];
            c  = s[ic];
            d  = s[id];
            case (step)
                STEP_AD16: begin
                    a = a + b;
                    d = rotl(d ^ a, ROT_16);
                end
                STEP_CB12: begin
                    c = c + d;
                    b = rotl(b ^ c, ROT_12);
                end
                STEP_AD8: begin
                    a = a + b;
                    d = rotl(d ^ a, ROT_8);
                end
                STEP_CB7: begin
                    c = c + d;
                    b = rotl(b ^ c, ROT_7);
                end
                default: begin
                    a = s[ia];
                end
            endcase
            r     = s;
            r[ia] = a;
            r[ib] = b;
            r[ic] = c;
            r[id] = d;
            return r;
        end
    endfunction

endpackage

/* hdl/cbp_if.sv */
interface cbp_in_if;
    logic                          valid;
    logic                          ready;
    logic [cbp_pkg::FIELD_W-1:0]   in_words_0_1;
    logic [cbp_pkg::FIELD_W-1:0]   in_words_2_3;
    logic [cbp_pkg::FIELD_W-1:0]   in_words_4_5;
    logic [cbp_pkg::FIELD_W-1:0]   in_words_6_7;
    logic [cbp_pkg::FIELD_W-1:0]   in_words_8_9;
    logic [cbp_pkg::FIELD_W-1:0]   in_words_10_11;
    logic [cbp_pkg::FIELD_W-1:0]   in_words_12_13;
    logic [cbp_pkg::FIELD_W-1:0]   in_words_14_15;

    modport source (
        output valid, in_words_0_1, in_words_2_3, in_words_4_5, in_words_6_7,
               in_words_8_9, in_words_10_11, in_words_12_13, in_words_14_15,
        input  ready
    );
    modport sink (
        input  valid, in_words_0_1, in_words_2_3, in_words_4_5, in_words_6_7,
               in_words_8_9, in_words_10_11, in_words_12_13, in_words_14_15,
        output ready
    );
endinterface

interface cbp_out_if;
    logic                          valid;
    logic                          ready;
    logic [cbp_pkg::FIELD_W-1:0]   out_words_0_1;
    logic [cbp_pkg::FIELD_W-1:0]   out_words_2_3;
    logic [cbp_pkg::FIELD_W-1:0]   out_words_4_5;
    logic [cbp_pkg::FIELD_W-1:0]   out_words_6_7;
    logic [cbp_pkg::FIELD_W-1:0]   out_words_8_9;
    logic [cbp_pkg::FIELD_W-1:0]   out_words_10_11;
    logic [cbp_pkg::FIELD_W-1:0]   out_words_12_13;
    logic [cbp_pkg::FIELD_W-1:0]   out_words_14_15;

    modport source (
        output valid, out_words_0_1, out_words_2_3, out_words_4_5, out_words_6_7,
               out_words_8_9, out_words_10_11, out_words_12_13, out_words_14_15,
        input  ready
    );
    modport sink (
        input  valid, out_words_0_1, out_words_2_3, out_words_4_5, out_words_6_7,
               out_words_8_9, out_words_10_11, out_words_12_13, out_words_14_15,
        output ready
    );
endinterface

/* hdl/cbp_round_stage.sv */
module cbp_round_stage #(
    parameter logic           DIAG = 1'b0,
    parameter cbp_pkg::t_step STEP = cbp_pkg::STEP_AD16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  cbp_pkg::t_state i_state,
    output logic            o_valid,
    output cbp_pkg::t_state o_state
);

    logic            r_valid;
    cbp_pkg::t_state r_state;
    cbp_pkg::t_state n_state;

    // the four quarter-rounds touch disjoint words
    always_comb begin
        n_state = i_state;
        for (int q = 0; q < 4; q++) begin
            n_state = cbp_pkg::qr_step(n_state, DIAG, STEP, 2'(q));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_state <= n_state;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;

endmodule

/* hdl/chacha_block_permutation.sv */
// Channel  | Dir | Modport           | Payload
// i_blk    | in  | cbp_in_if.sink    | in_words_0_1 .. in_words_14_15, 2 x 32-bit words each
// o_blk    | out | cbp_out_if.source | out_words_0_1 .. out_words_14_15, permuted words
//
// The pipeline has one register stage per add/xor/rotate step of each half round,
// then the output register. One block per cycle while a stalled output does not hold the pipeline.
// Synchronous active-low reset clears the valid bits only.
// A stalled output holds its word; the pipeline keeps moving while its last
// stage is empty, so new blocks are still accepted.
`include "assert_macros.svh"

module chacha_block_permutation #(
    parameter int DOUBLE_ROUNDS = cbp_pkg::DOUBLE_ROUNDS_D
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cbp_in_if.sink        i_blk,
    cbp_out_if.source     o_blk
);

    localparam int STAGES = cbp_pkg::STEPS_PER_DR * DOUBLE_ROUNDS;

    cbp_pkg::t_state w_state [STAGES+1];
    logic [STAGES:0] w_valid;
    logic            w_en;
    logic            w_out_load;

    logic            r_out_valid;
    cbp_pkg::t_state r_out_state;

    assign w_out_load = !r_out_valid || o_blk.ready;
    assign w_en       = !w_valid[STAGES] || w_out_load;
    assign i_blk.ready = w_en;

    assign w_valid[0]        = i_blk.valid;
    assign w_state[0][1:0]   = i_blk.in_words_0_1;
    assign w_state[0][3:2]   = i_blk.in_words_2_3;
    assign w_state[0][5:4]   = i_blk.in_words_4_5;
    assign w_state[0][7:6]   = i_blk.in_words_6_7;
    assign w_state[0][9:8]   = i_blk.in_words_8_9;
    assign w_state[0][11:10] = i_blk.in_words_10_11;
    assign w_state[0][13:12] = i_blk.in_words_12_13;
    assign w_state[0][15:14] = i_blk.in_words_14_15;

    for (genvar j = 0; j < STAGES; j++) begin : g_stage
        localparam logic           DIAG = 1'((j / 4) % 2);
        localparam cbp_pkg::t_step STEP = cbp_pkg::t_step'(j % 4);

        cbp_round_stage #(
            .DIAG (DIAG),
            .STEP (STEP)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[j]),
            .i_state (w_state[j]),
            .o_valid (w_valid[j+1]),
            .o_state (w_state[j+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= w_valid[STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_state <= w_state[STAGES];
        end
    end

    assign o_blk.valid           = r_out_valid;
    assign o_blk.out_words_0_1   = r_out_state[1:0];
    assign o_blk.out_words_2_3   = r_out_state[3:2];
    assign o_blk.out_words_4_5   = r_out_state[5:4];
    assign o_blk.out_words_6_7   = r_out_state[7:6];
    assign o_blk.out_words_8_9   = r_out_state[9:8];
    assign o_blk.out_words_10_11 = r_out_state[11:10];
    assign o_blk.out_words_12_13 = r_out_state[13:12];
    assign o_blk.out_words_14_15 = r_out_state[15:14];

    `ASSERT_SAME(a_stall_when_full, i_clk, i_rst_n,
        w_valid[STAGES] && r_out_valid && !o_blk.ready, !i_blk.ready,
        "pipeline advanced into a full output register")

    `ASSERT_NEXT(a_tail_held, i_clk, i_rst_n,
        w_valid[STAGES] && !w_en, w_valid[STAGES] && $stable(w_state[STAGES]),
        "stalled tail word changed")

    `ASSERT_NEXT(a_out_held, i_clk, i_rst_n,
        r_out_valid && !o_blk.ready, r_out_valid && $stable(r_out_state),
        "waiting output word changed")

endmodule
